// ===== design/mgcpc_pkg.sv =====
`timescale 1ns / 1ps

package mgcpc_pkg;

    localparam int unsigned IDLE_W   = 17;
    localparam int unsigned SECS_W   = 16;
    localparam int unsigned TOTAL_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    localparam logic [SECS_W-1:0] ARM_WINDOW_RESET  = 16'd20;
    localparam logic [SECS_W-1:0] POST_RECORD_RESET = 16'd30;
    localparam logic [SECS_W-1:0] BOOT_IDLE_RESET   = 16'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_RECORD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_IDLE   = 2'd3;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_MOTION  = 3'd1,
        CMD_REQUIRE = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_REC_END = 3'd4,
        CMD_SET_REC = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_BOOT   = 2'd0,
        KIND_REC    = 2'd1,
        KIND_MOTION = 2'd2
    } t_kind;

    typedef struct packed {
        logic              gate_enable;
        logic [SECS_W-1:0] arm_window_secs;
        logic [SECS_W-1:0] post_record_secs;
        logic [SECS_W-1:0] boot_idle_secs;
    } t_cfg;

    typedef struct packed {
        logic               camera_active;
        logic               granted;
        logic               suspended_now;
        logic               resumed_now;
        logic [TOTAL_W-1:0] client_total;
    } t_result;

endpackage

// ===== design/mgcpc_cfg.sv =====
`timescale 1ns / 1ps

module mgcpc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mgcpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mgcpc_pkg::SECS_W-1:0]        i_cfg_data,
    output mgcpc_pkg::t_cfg                     o_cfg
);

    mgcpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_enable      <= 1'b0;
            r_cfg.arm_window_secs  <= mgcpc_pkg::ARM_WINDOW_RESET;
            r_cfg.post_record_secs <= mgcpc_pkg::POST_RECORD_RESET;
            r_cfg.boot_idle_secs   <= mgcpc_pkg::BOOT_IDLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mgcpc_pkg::CFG_GATE_ENABLE: r_cfg.gate_enable      <= i_cfg_data[0];
                mgcpc_pkg::CFG_ARM_WINDOW:  r_cfg.arm_window_secs  <= i_cfg_data;
                mgcpc_pkg::CFG_POST_RECORD: r_cfg.post_record_secs <= i_cfg_data;
                mgcpc_pkg::CFG_BOOT_IDLE:   r_cfg.boot_idle_secs   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/mgcpc_core.sv =====
`timescale 1ns / 1ps

module mgcpc_core #(
    parameter int unsigned MAX_CLIENTS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  mgcpc_pkg::t_cmd      i_cmd,
    input  logic                 i_flag,
    input  mgcpc_pkg::t_cfg      i_cfg,
    output mgcpc_pkg::t_result   o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_CLIENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLIENTS);

    logic                          r_active;
    mgcpc_pkg::t_kind              r_kind;
    logic [mgcpc_pkg::IDLE_W-1:0]  r_idle;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_rec;

    logic                          n_active;
    mgcpc_pkg::t_kind              n_kind;
    logic [mgcpc_pkg::IDLE_W-1:0]  n_idle;
    logic [CNT_W-1:0]              n_cnt;
    logic                          n_rec;

    logic                          w_en;
    logic                          w_granted;
    logic                          w_suspended;
    logic                          w_resumed;
    logic [mgcpc_pkg::SECS_W-1:0]  w_timeout;
    logic [CNT_W+mgcpc_pkg::TOTAL_W-1:0] w_cnt_ext;

    assign w_en = i_cfg.gate_enable;

    always_comb begin
        n_active    = r_active;
        n_kind      = r_kind;
        n_idle      = r_idle;
        n_cnt       = r_cnt;
        n_rec       = r_rec;
        w_granted   = 1'b0;
        w_suspended = 1'b0;
        w_resumed   = 1'b0;
        w_timeout   = i_cfg.arm_window_secs;

        if (!w_en && !r_active) begin
            n_active  = 1'b1;
            n_kind    = mgcpc_pkg::KIND_MOTION;
            n_idle    = '0;
            w_resumed = 1'b1;
        end

        case (n_kind)
            mgcpc_pkg::KIND_BOOT: w_timeout = i_cfg.boot_idle_secs;
            mgcpc_pkg::KIND_REC:  w_timeout = i_cfg.post_record_secs;
            default:              w_timeout = i_cfg.arm_window_secs;
        endcase

        case (i_cmd)
            mgcpc_pkg::CMD_TICK: begin
                if (n_idle != mgcpc_pkg::IDLE_MAX) begin
                    n_idle = n_idle + 1'b1;
                end
                if (w_en && n_active && !n_rec && (n_cnt == '0) &&
                    (n_idle > {1'b0, w_timeout})) begin
                    n_active    = 1'b0;
                    w_suspended = 1'b1;
                end
            end
            mgcpc_pkg::CMD_MOTION: begin
                n_kind = mgcpc_pkg::KIND_MOTION;
                n_idle = '0;
                if (w_en && !n_active) begin
                    n_active  = 1'b1;
                    w_resumed = 1'b1;
                end
            end
            mgcpc_pkg::CMD_REQUIRE: begin
                w_granted = 1'b1;
                if (w_en) begin
                    if (!n_active) begin
                        n_active  = 1'b1;
                        n_kind    = mgcpc_pkg::KIND_MOTION;
                        n_idle    = '0;
                        w_resumed = 1'b1;
                    end
                    if (n_cnt < CNT_MAX) begin
                        n_cnt = n_cnt + 1'b1;
                    end
                end
            end
            mgcpc_pkg::CMD_RELEASE: begin
                if (w_en && (n_cnt != '0)) begin
                    n_cnt = n_cnt - 1'b1;
                end
            end
            mgcpc_pkg::CMD_REC_END: begin
                if (w_en) begin
                    n_kind = mgcpc_pkg::KIND_REC;
                    n_idle = '0;
                end
            end
            mgcpc_pkg::CMD_SET_REC: begin
                if (w_en) begin
                    n_rec = i_flag;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_kind   <= mgcpc_pkg::KIND_BOOT;
            r_idle   <= '0;
            r_cnt    <= '0;
            r_rec    <= 1'b0;
        end else if (i_step) begin
            r_active <= n_active;
            r_kind   <= n_kind;
            r_idle   <= n_idle;
            r_cnt    <= n_cnt;
            r_rec    <= n_rec;
        end
    end

    assign w_cnt_ext = {{mgcpc_pkg::TOTAL_W{1'b0}}, n_cnt};

    assign o_result.camera_active = n_active;
    assign o_result.granted       = w_granted;
    assign o_result.suspended_now = w_suspended;
    assign o_result.resumed_now   = w_resumed;
    assign o_result.client_total  = w_cnt_ext[mgcpc_pkg::TOTAL_W-1:0];

`ifndef SYNTHESIS
    a_no_suspend_and_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_suspended && w_resumed))
        else $error("suspend and resume in the same word");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("client count above its limit");

    a_disabled_keeps_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !w_en) |=> r_active)
        else $error("camera in standby after a step with the gate disabled");

    a_suspend_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_suspended) |=> (!r_active && (r_cnt == '0)))
        else $error("suspend left the camera active or with clients");
`endif

endmodule

// ===== design/motion_gated_camera_power_control_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                      Payload
// in        i_in_valid / o_in_ready        i_command, i_recording_flag
// out       o_out_valid / i_out_ready      o_camera_active, o_granted, o_suspended_now,
//                                          o_resumed_now, o_client_total
// cfg       i_cfg_we                       i_cfg_index, i_cfg_data
//
// A word is registered at the input, evaluated combinationally against the state and
// written to the output register (which drives o_out_valid) with the state update.
// One word per cycle is sustained while i_out_ready stays high.
// Synchronous active-low reset restores the register defaults and the boot state.
// A stalled output holds the input register; o_in_ready falls only when both are full.

module motion_gated_camera_power_control_top #(
    parameter int unsigned MAX_CLIENTS = 15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_command,
    input  logic                              i_recording_flag,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_camera_active,
    output logic                              o_granted,
    output logic                              o_suspended_now,
    output logic                              o_resumed_now,
    output logic [mgcpc_pkg::TOTAL_W-1:0]     o_client_total,
    input  logic                              i_cfg_we,
    input  logic [mgcpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mgcpc_pkg::SECS_W-1:0]      i_cfg_data
);

    logic                 r_in_valid;
    mgcpc_pkg::t_cmd      r_cmd;
    logic                 r_flag;
    logic                 r_out_valid;
    mgcpc_pkg::t_result   r_out;

    logic                 w_adv;
    logic                 w_in_take;
    mgcpc_pkg::t_cfg      w_cfg;
    mgcpc_pkg::t_result   w_result;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_take  = i_in_valid && o_in_ready;

    mgcpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mgcpc_core #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_cmd    (r_cmd),
        .i_flag   (r_flag),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd  <= mgcpc_pkg::t_cmd'(i_command);
            r_flag <= i_recording_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_camera_active = r_out.camera_active;
    assign o_granted       = r_out.granted;
    assign o_suspended_now = r_out.suspended_now;
    assign o_resumed_now   = r_out.resumed_now;
    assign o_client_total  = r_out.client_total;

`ifndef SYNTHESIS
    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_cmd) && $stable(r_flag)))
        else $error("pending input word lost while output stalled");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result overwritten while output stalled");

    a_advance_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("evaluated word did not reach the output register");
`endif

endmodule
